@@ src/binary_lifting_lca_engine_core_assert.svh @@
// Assertion macros for the LCA engine; define NO_ASSERTIONS to drop them.
`ifndef BINARY_LIFTING_LCA_ENGINE_CORE_ASSERT_SVH
`define BINARY_LIFTING_LCA_ENGINE_CORE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define BLLCA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");
`define BLLCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BLLCA_ASSERT_ALWAYS(lbl, expr)
`define BLLCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ src/bllca_pkg.sv @@
package bllca_pkg;
  localparam int MAX_NODES   = 1024;
  localparam int NODE_W      = 10;
  localparam int LIFT_LEVELS = 10;
  localparam int LVL_W       = 4;
  localparam int DEPTH_W     = 10;
  localparam int CNT_W       = 11;
  localparam int ENTRY_W     = NODE_W + 1;
  localparam int TBL_AW      = NODE_W + LVL_W;
  localparam int TBL_DEPTH   = MAX_NODES * (2 ** LVL_W);

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_BUILD = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  typedef struct packed {
    logic              valid;
    logic [NODE_W-1:0] node;
  } entry_t;
endpackage

@@ src/bllca_ram.sv @@
module bllca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ src/binary_lifting_lca_engine_core.sv @@
// Channel | handshake             | payload
// in      | in_valid / in_ready   | command, node_a, node_b, has_parent
// out     | out_valid / out_ready | ancestor_node, no_common_ancestor
// cfg     | cfg_we (no wait)      | cfg_wdata -> node_count
//
// Work: load writes a node's entry and depth, reading the parent depth first when
// it has a parent; build fills 9 levels over min(node_count,1024) nodes; query lifts
// the deeper node by the depth difference, then climbs both nodes jointly and reads
// the last parent when the nodes still differ. The single read port of the ancestor
// table memory orders these reads; one item is worked at a time.
// Reset: synchronous, clears control state and node_count to 1; the memories are
// not cleared. A finished result waits in the output register while the next
// item is taken; a query only stalls in its last step when that register is full.
`include "binary_lifting_lca_engine_core_assert.svh"
module binary_lifting_lca_engine_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bllca_pkg::CNT_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  command,
  input  logic [bllca_pkg::NODE_W-1:0] node_a,
  input  logic [bllca_pkg::NODE_W-1:0] node_b,
  input  logic                        has_parent,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [bllca_pkg::NODE_W-1:0] ancestor_node,
  output logic                        no_common_ancestor
);
  import bllca_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_LD_RD, S_LD_WR,
    S_B_RD1, S_B_RD2, S_B_WR,
    S_Q_DA, S_Q_DB, S_Q_SW, S_Q_LIFT, S_Q_LIFTW,
    S_Q_CA, S_Q_CB, S_Q_CC, S_Q_FIN, S_Q_FW, S_Q_OUT
  } state_t;

  state_t state;
  logic [CNT_W-1:0]   node_count;
  logic [NODE_W-1:0]  a, b;
  logic               hp;
  logic [DEPTH_W-1:0] da, d;
  logic [LVL_W-1:0]   f, lv, jp;
  logic [NODE_W-1:0]  bi;
  logic               use_rd;
  entry_t             ea;
  logic [NODE_W-1:0]  res_node;
  logic               res_fail;

  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  entry_t             tbl_wdata, tbl_rdata;
  logic               dep_we;
  logic [NODE_W-1:0]  dep_waddr, dep_raddr;
  logic [DEPTH_W-1:0] dep_wdata, dep_rdata;
  logic [CNT_W-1:0]   limit;
  logic               out_free;

  bllca_ram #(.WIDTH(ENTRY_W), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk(clk), .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  bllca_ram #(.WIDTH(DEPTH_W), .DEPTH(MAX_NODES)) u_dep (
    .clk(clk), .we(dep_we), .waddr(dep_waddr), .wdata(dep_wdata),
    .raddr(dep_raddr), .rdata(dep_rdata)
  );

  // Build covers nodes 0 .. limit-1, capped at the table size.
  assign limit    = (node_count > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count;
  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Memory port steering per state.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {a, LVL_W'(0)};
    tbl_wdata = '0;
    tbl_raddr = {b, f};
    dep_we    = 1'b0;
    dep_waddr = a;
    dep_wdata = '0;
    dep_raddr = b;
    case (state)
      S_LD_WR: begin
        tbl_we = 1'b1;
        dep_we = 1'b1;
        if (hp) begin
          tbl_wdata = '{valid: 1'b1, node: b};
          // saturate the depth at its largest value
          dep_wdata = (&dep_rdata) ? dep_rdata : dep_rdata + DEPTH_W'(1);
        end
      end
      S_B_RD1: tbl_raddr = {bi, jp};
      S_B_RD2: tbl_raddr = {tbl_rdata.node, jp};
      S_B_WR: begin
        tbl_we    = 1'b1;
        tbl_waddr = {bi, jp + LVL_W'(1)};
        tbl_wdata = use_rd ? tbl_rdata : '0;
      end
      S_Q_DA:  dep_raddr = a;
      S_Q_CA:  tbl_raddr = {a, lv};
      S_Q_CB:  tbl_raddr = {b, lv};
      S_Q_FIN: tbl_raddr = {a, LVL_W'(0)};
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      node_count <= CNT_W'(1);
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_count <= cfg_wdata;
      end
      // a result leaving in the same cycle as a new one is loaded stays valid
      if (out_valid && out_ready && state != S_Q_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            a  <= node_a;
            b  <= node_b;
            hp <= has_parent;
            case (command)
              CMD_LOAD:  state <= has_parent ? S_LD_RD : S_LD_WR;
              CMD_BUILD: begin
                bi <= '0;
                jp <= '0;
                if (limit != '0 && LIFT_LEVELS > 1) begin
                  state <= S_B_RD1;
                end
              end
              CMD_QUERY: state <= S_Q_DA;
              default: ;  // drop unknown command
            endcase
          end
        end
        S_LD_RD: state <= S_LD_WR;
        S_LD_WR: state <= S_IDLE;
        S_B_RD1: state <= S_B_RD2;
        S_B_RD2: begin
          use_rd <= tbl_rdata.valid;
          state  <= S_B_WR;
        end
        S_B_WR: begin
          if ({1'b0, bi} == limit - CNT_W'(1)) begin
            bi <= '0;
            jp <= jp + LVL_W'(1);
            state <= (jp == LVL_W'(LIFT_LEVELS - 2)) ? S_IDLE : S_B_RD1;
          end else begin
            bi    <= bi + NODE_W'(1);
            state <= S_B_RD1;
          end
        end
        S_Q_DA: state <= S_Q_DB;
        S_Q_DB: begin
          da    <= dep_rdata;
          state <= S_Q_SW;
        end
        S_Q_SW: begin
          // keep a as the shallower node
          if (da > dep_rdata) begin
            a <= b;
            b <= a;
            d <= da - dep_rdata;
          end else begin
            d <= dep_rdata - da;
          end
          f     <= '0;
          state <= S_Q_LIFT;
        end
        S_Q_LIFT: begin
          if (d == '0) begin
            if (a == b) begin
              res_node <= a;
              res_fail <= 1'b0;
              state    <= S_Q_OUT;
            end else begin
              lv    <= LVL_W'(LIFT_LEVELS - 1);
              state <= S_Q_CA;
            end
          end else if (d[0]) begin
            if (f >= LVL_W'(LIFT_LEVELS)) begin
              res_node <= '0;
              res_fail <= 1'b1;
              state    <= S_Q_OUT;
            end else begin
              state <= S_Q_LIFTW;
            end
          end else begin
            d <= d >> 1;
            f <= f + LVL_W'(1);
          end
        end
        S_Q_LIFTW: begin
          if (!tbl_rdata.valid) begin
            res_node <= '0;
            res_fail <= 1'b1;
            state    <= S_Q_OUT;
          end else begin
            b     <= tbl_rdata.node;
            d     <= d >> 1;
            f     <= f + LVL_W'(1);
            state <= S_Q_LIFT;
          end
        end
        S_Q_CA: state <= S_Q_CB;
        S_Q_CB: begin
          ea    <= tbl_rdata;
          state <= S_Q_CC;
        end
        S_Q_CC: begin
          if (ea.valid && ea != tbl_rdata && !tbl_rdata.valid) begin
            res_node <= '0;
            res_fail <= 1'b1;
            state    <= S_Q_OUT;
          end else begin
            if (ea.valid && ea != tbl_rdata) begin
              a <= ea.node;
              b <= tbl_rdata.node;
            end
            if (lv == '0) begin
              state <= S_Q_FIN;
            end else begin
              lv    <= lv - LVL_W'(1);
              state <= S_Q_CA;
            end
          end
        end
        S_Q_FIN: state <= S_Q_FW;
        S_Q_FW: begin
          res_node <= tbl_rdata.valid ? tbl_rdata.node : '0;
          res_fail <= !tbl_rdata.valid;
          state    <= S_Q_OUT;
        end
        S_Q_OUT: begin
          // hold the result until the output register is free
          if (out_free) begin
            ancestor_node      <= res_node;
            no_common_ancestor <= res_fail;
            out_valid          <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `BLLCA_ASSERT_NEXT(a_out_only_from_query, !out_valid && state != S_Q_OUT, !out_valid)
  `BLLCA_ASSERT_ALWAYS(a_build_skips_level0, !(state == S_B_WR && tbl_waddr[LVL_W-1:0] == '0))
  `BLLCA_ASSERT_ALWAYS(a_depth_write_in_load, !dep_we || state == S_LD_WR)
  `BLLCA_ASSERT_ALWAYS(a_fail_zero_node, !(out_valid && no_common_ancestor) || ancestor_node == '0)
endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bllca_pkg::*;

  // Command 3 has no meaning; the block must drop it without a result.
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 320;
  localparam int CHAIN_LEN = 128;

  typedef struct packed {
    logic [NODE_W-1:0] node;
    logic              none;
  } lca_result_t;

  // Scoreboard: tracks the forest and the lifting table, and holds the
  // answers of accepted queries until the block returns them.
  class lca_scoreboard;
    entry_t            lift_tbl[MAX_NODES][LIFT_LEVELS];
    logic [DEPTH_W-1:0] depth[MAX_NODES];
    logic [CNT_W-1:0]  node_count;
    lca_result_t       answers[$];
    int                errors;

    function void clear();
      node_count = CNT_W'(1);
      answers.delete();
      errors = 0;
    endfunction

    function entry_t lift_entry(int n, int lvl);
      entry_t none_e;
      none_e = '0;
      if (lvl >= LIFT_LEVELS) return none_e;
      return lift_tbl[n][lvl];
    endfunction

    function void rebuild();
      int lim;
      entry_t prev;
      lim = (node_count > MAX_NODES) ? MAX_NODES : node_count;
      for (int j = 1; j < LIFT_LEVELS; j++)
        for (int i = 0; i < lim; i++) begin
          prev = lift_tbl[i][j-1];
          lift_tbl[i][j] = prev.valid ? lift_tbl[prev.node][j-1] : entry_t'('0);
        end
    endfunction

    function lca_result_t find_lca(int a, int b);
      lca_result_t r;
      int t, d, f;
      entry_t ea, eb;
      r = '{node: '0, none: 1'b1};
      if (depth[a] > depth[b]) begin
        t = a; a = b; b = t;
      end
      d = depth[b] - depth[a];
      f = 0;
      while (d != 0) begin
        if (d & 1) begin
          if (f >= LIFT_LEVELS) return r;
          eb = lift_entry(b, f);
          if (!eb.valid) return r;
          b = eb.node;
        end
        f++;
        d = d >> 1;
      end
      if (a == b) return '{node: a[NODE_W-1:0], none: 1'b0};
      for (int lv = LIFT_LEVELS - 1; lv >= 0; lv--) begin
        ea = lift_entry(a, lv);
        eb = lift_entry(b, lv);
        if (ea.valid && ea != eb) begin
          if (!eb.valid) return r;
          a = ea.node;
          b = eb.node;
        end
      end
      ea = lift_entry(a, 0);
      if (!ea.valid) return r;
      return '{node: ea.node, none: 1'b0};
    endfunction

    // Note one accepted input transfer.
    function void note_input(logic [1:0] cmd, logic [NODE_W-1:0] a, logic [NODE_W-1:0] b,
                             logic hp);
      case (cmd)
        CMD_LOAD: begin
          if (hp) begin
            lift_tbl[a][0] = '{valid: 1'b1, node: b};
            depth[a] = (depth[b] >= 1023) ? 10'd1023 : depth[b] + 1'b1;
          end else begin
            lift_tbl[a][0] = '0;
            depth[a] = '0;
          end
        end
        CMD_BUILD: rebuild();
        CMD_QUERY: answers.insert(answers.size(), find_lca(a, b));
        default: ;
      endcase
    endfunction

    // Check one output transfer against the oldest answer.
    function void check_result(logic [NODE_W-1:0] anc, logic none);
      lca_result_t want;
      if (answers.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result: anc=%0d none=%0b", anc, none);
        return;
      end
      want = answers.pop_front();
      if (anc !== want.node || none !== want.none) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected anc=%0d none=%0b, got anc=%0d none=%0b",
                   want.node, want.none, anc, none);
      end
    endfunction
  endclass

  logic                clk;
  logic                rst;
  logic                cfg_we;
  logic [CNT_W-1:0]    cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          command;
  logic [NODE_W-1:0]   node_a;
  logic [NODE_W-1:0]   node_b;
  logic                has_parent;
  logic                out_valid;
  logic                out_ready;
  logic [NODE_W-1:0]   ancestor_node;
  logic                no_common_ancestor;

  lca_scoreboard sb;
  bit calm;          // when set, neither side inserts idle cycles
  bit all_built;     // every node below CHAIN_LEN has a full set of table entries
  int idle_cycles;
  int random_sent;

  binary_lifting_lca_engine_core dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .command(command), .node_a(node_a), .node_b(node_b), .has_parent(has_parent),
    .out_valid(out_valid), .out_ready(out_ready),
    .ancestor_node(ancestor_node), .no_common_ancestor(no_common_ancestor)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Drive one item; hold valid and payload until the transfer.
  task automatic send(logic [1:0] cmd, int a, int b, logic hp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    node_a     <= a[NODE_W-1:0];
    node_b     <= b[NODE_W-1:0];
    has_parent <= hp;
    do @(posedge clk); while (!in_ready);
    sb.note_input(cmd, a[NODE_W-1:0], b[NODE_W-1:0], hp);
  endtask

  // Drop valid and wait until every answer is back.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.answers.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  // Only called once the block is idle: a query has followed any build.
  task automatic write_count(int n);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= n[CNT_W-1:0];
    sb.node_count = n[CNT_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Pick a node whose depth and table are fully written.
  function automatic int pick_node(int n);
    if (all_built && $urandom_range(0, 3) == 0) return $urandom_range(0, CHAIN_LEN - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // Load a random forest over nodes 0..n-1, build, then query it.
  task automatic random_phase();
    int n, q;
    calm = ($urandom_range(0, 4) == 0);
    n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 40);
    write_count(n);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 1023),
             1'($urandom_range(0, 1)));
        random_sent++;
      end
      if (i == 0 || $urandom_range(0, 5) == 0)
        send(CMD_LOAD, i, $urandom_range(0, 1023), 1'b0);
      else
        send(CMD_LOAD, i, $urandom_range(0, i - 1), 1'b1);
      random_sent++;
    end
    send(CMD_BUILD, $urandom_range(0, 1023), $urandom_range(0, 1023),
         1'($urandom_range(0, 1)));
    q = $urandom_range(5, 20);
    for (int k = 0; k < q; k++) begin
      int a;
      a = pick_node(n);
      if ($urandom_range(0, 7) == 0) send(CMD_QUERY, a, a, 1'($urandom_range(0, 1)));
      else send(CMD_QUERY, a, pick_node(n), 1'($urandom_range(0, 1)));
      random_sent++;
    end
  endtask

  // Return side: stall a random number of cycles, then accept one result.
  initial begin
    out_ready = 1'b0;
    @(negedge rst);
    forever begin
      int stall;
      stall = calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) sb.check_result(ancestor_node, no_common_ancestor);
  end

  // Watchdog: abort when nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    sb = new();
    sb.clear();
    calm = 1'b0;
    all_built = 1'b0;
    random_sent = 0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    command = CMD_LOAD;
    node_a = '0;
    node_b = '0;
    has_parent = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset count of one: a single root, built and queried against itself.
    send(CMD_LOAD, 0, 1023, 1'b0);
    send(CMD_BUILD, 0, 0, 1'b0);
    send(CMD_QUERY, 0, 0, 1'b0);
    send(CMD_NONE, 1023, 1023, 1'b1);

    // Chain 0 <- 1 <- ... <- CHAIN_LEN-1, built over every loaded node.
    write_count(CHAIN_LEN);
    calm = 1'b1;
    send(CMD_LOAD, 0, 0, 1'b0);
    for (int i = 1; i < CHAIN_LEN; i++) send(CMD_LOAD, i, i - 1, 1'b1);
    send(CMD_BUILD, 0, 0, 1'b0);
    all_built = 1'b1;
    calm = 1'b0;
    send(CMD_QUERY, CHAIN_LEN - 1, 0, 1'b0);
    send(CMD_QUERY, CHAIN_LEN - 1, CHAIN_LEN - 1, 1'b1);
    send(CMD_QUERY, 64, 100, 1'b0);
    send(CMD_QUERY, 42, 85, 1'b1);
    // Close the chain into a loop: node 0 now hangs below the last node,
    // and its upper table levels stay stale until the next build.
    send(CMD_LOAD, 0, CHAIN_LEN - 1, 1'b1);
    send(CMD_QUERY, 0, 1, 1'b0);
    send(CMD_QUERY, CHAIN_LEN - 1, 0, 1'b0);
    // Rebuild over the loop; then a count of zero builds nothing.
    send(CMD_BUILD, 0, 0, 1'b0);
    send(CMD_QUERY, 0, 70, 1'b0);
    send(CMD_QUERY, 5, 90, 1'b0);
    write_count(0);
    send(CMD_LOAD, 0, 0, 1'b0);
    send(CMD_BUILD, 0, 0, 1'b0);
    send(CMD_QUERY, 0, 3, 1'b0);
    send(CMD_QUERY, 2, 3, 1'b0);

    while (random_sent < RANDOM_ITEMS) random_phase();

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.answers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
